/* rtl/cdd_pkg.sv */
// Shared widths, constants and calendar tables for the date difference core.
package cdd_pkg;

    // Field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int DIFF_W   = 22;
    localparam int WDAY_W   = 3;
    localparam int DAYNUM_W = 23;
    localparam int ZSUM_W   = 11;
    localparam int Q100_W   = 8;
    localparam int R100_W   = 7;
    localparam int Q7_W     = 9;

    // Stream payload widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    // Calendar bounds
    localparam logic [15:0]       MAX_YEAR = 16'd9999;
    localparam logic [DIFF_W-1:0] DAYS_MAX = 22'h3FFFFF;

    // Reciprocal constants: y / 100 = (y * 5243) >> 19 for 14-bit y,
    // s / 7 = (s * 2341) >> 14 for 11-bit s
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SH  = 19;
    localparam logic [11:0] DIV7_MUL   = 12'd2341;
    localparam int          DIV7_SH    = 14;

    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [YEAR_W-1:0]  year_t;

    // Days in a common year's month
    function automatic logic [4:0] month_len(input month_t m);
        logic [4:0] len;
        case (m)
            4'd2:                          len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:       len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                  len = 5'd31;
            default:                       len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of the month
    function automatic logic [8:0] days_before(input month_t m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // Zeller month term floor(13 * (m' + 1) / 5), with January and
    // February counted as months 13 and 14 of the previous year
    function automatic logic [5:0] zeller_month_term(input month_t m);
        logic [5:0] t;
        case (m)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/calendar_date_difference_core.sv */
// Date pair checker: day count between two Gregorian dates and Zeller weekdays.
// Pipeline: five register stages, stage 1 through stage 5, the last being the output register.
// Throughput: one date pair per cycle while the output is not stalled by m_axis_tready.
// A stage loads when empty or when the next stage moves, so bubbles close up.
// Path depth is set by the 14x13 reciprocal multiply and the day-number sum.
// Reset (rst_n low, asynchronous) clears the stage valid bits only.
module calendar_date_difference_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [4:0] day_first, [8:5] month_first, [22:9] year_first,
    // [27:23] day_second, [31:28] month_second, [45:32] year_second, [47:46] zero
    input  logic [cdd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [21:0] days_between, [24:22] weekday_first, [27:25] weekday_second,
    // [31:28] zero
    output logic [cdd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] dates_valid
    output logic                              m_axis_tuser
);
    import cdd_pkg::*;

    // Input unpack
    day_t   in_day   [2];
    month_t in_month [2];
    year_t  in_year  [2];

    assign in_day[0]   = s_axis_tdata[4:0];
    assign in_month[0] = s_axis_tdata[8:5];
    assign in_year[0]  = s_axis_tdata[22:9];
    assign in_day[1]   = s_axis_tdata[27:23];
    assign in_month[1] = s_axis_tdata[31:28];
    assign in_year[1]  = s_axis_tdata[45:32];

    // Stage handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !s5_valid_reg || m_axis_tready;
    assign rdy4 = !s4_valid_reg || rdy5;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;
    assign s_axis_tready = rdy1;

    // Stage 1: raw fields and year / 100
    day_t              s1_day_reg   [2];
    month_t            s1_month_reg [2];
    year_t             s1_year_reg  [2];
    logic [Q100_W-1:0] s1_q100_reg  [2];
    logic [Q100_W-1:0] s1_q100_next [2];
    logic [26:0]       div100_prod  [2];

    // Stage 2: validity, leap year, day-number and Zeller terms
    logic              s2_ok_reg,     s2_ok_next;
    year_t             s2_p_reg   [2];
    year_t             s2_p_next  [2];
    logic [Q100_W-1:0] s2_pq_reg  [2];
    logic [Q100_W-1:0] s2_pq_next [2];
    logic [8:0]        s2_dom_reg [2];
    logic [8:0]        s2_dom_next[2];
    logic [R100_W-1:0] s2_k_reg   [2];
    logic [R100_W-1:0] s2_k_next  [2];
    logic [Q100_W-1:0] s2_j_reg   [2];
    logic [Q100_W-1:0] s2_j_next  [2];
    logic [6:0]        s2_mt_reg  [2];
    logic [6:0]        s2_mt_next [2];

    logic [YEAR_W-1:0] rem100_full [2];
    logic [R100_W-1:0] rem100      [2];
    logic              cent_zero   [2];
    logic              leap        [2];
    logic [4:0]        mlen        [2];
    logic              date_ok     [2];

    // Stage 3: absolute day numbers and Zeller sums
    logic                s3_ok_reg;
    logic [DAYNUM_W-1:0] s3_n_reg   [2];
    logic [DAYNUM_W-1:0] s3_n_next  [2];
    logic [ZSUM_W-1:0]   s3_zs_reg  [2];
    logic [ZSUM_W-1:0]   s3_zs_next [2];

    // Stage 4: saturated difference and Zeller sum / 7
    logic                s4_ok_reg;
    logic [DIFF_W-1:0]   s4_days_reg, s4_days_next;
    logic [ZSUM_W-1:0]   s4_zs_reg  [2];
    logic [Q7_W-1:0]     s4_q7_reg  [2];
    logic [Q7_W-1:0]     s4_q7_next [2];
    logic [DAYNUM_W-1:0] n_diff;
    logic [DAYNUM_W-1:0] div7_prod  [2];

    // Stage 5: output register
    logic              s5_ok_reg;
    logic [DIFF_W-1:0] s5_days_reg;
    logic [WDAY_W-1:0] s5_wd_reg  [2];
    logic [WDAY_W-1:0] s5_wd_next [2];
    logic [ZSUM_W-1:0] rem7       [2];

    // Valid bits advance when the stage may load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_valid_reg <= s_axis_tvalid;
            if (rdy2) s2_valid_reg <= s1_valid_reg;
            if (rdy3) s3_valid_reg <= s2_valid_reg;
            if (rdy4) s4_valid_reg <= s3_valid_reg;
            if (rdy5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 1 logic: quotient by 100 through a reciprocal multiply
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            div100_prod[i]  = 27'(in_year[i]) * 27'(DIV100_MUL);
            s1_q100_next[i] = div100_prod[i][DIV100_SH +: Q100_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s1_day_reg[i]   <= in_day[i];
                s1_month_reg[i] <= in_month[i];
                s1_year_reg[i]  <= in_year[i];
                s1_q100_reg[i]  <= s1_q100_next[i];
            end
        end
    end

    // Stage 2 logic: remainder, leap rule, range checks, term selection
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rem100_full[i] = s1_year_reg[i] - YEAR_W'(s1_q100_reg[i] * 14'd100);
            rem100[i]      = rem100_full[i][R100_W-1:0];
            cent_zero[i]   = (rem100[i] == '0);
            leap[i]        = (s1_year_reg[i][1:0] == 2'b00)
                             && (!cent_zero[i] || (s1_q100_reg[i][1:0] == 2'b00));
            mlen[i]        = month_len(s1_month_reg[i])
                             + 5'((s1_month_reg[i] == 4'd2) && leap[i]);
            date_ok[i]     = (s1_year_reg[i] != '0)
                             && ({2'b00, s1_year_reg[i]} <= MAX_YEAR)
                             && (s1_month_reg[i] >= 4'd1) && (s1_month_reg[i] <= 4'd12)
                             && (s1_day_reg[i] != '0) && (s1_day_reg[i] <= mlen[i]);

            // Year before: p = y - 1, p / 100 follows from y / 100 and y % 100
            s2_p_next[i]  = s1_year_reg[i] - 14'd1;
            s2_pq_next[i] = cent_zero[i] ? s1_q100_reg[i] - 8'd1 : s1_q100_reg[i];
            s2_dom_next[i] = days_before(s1_month_reg[i])
                             + 9'((s1_month_reg[i] > 4'd2) && leap[i])
                             + 9'(s1_day_reg[i]);

            // Zeller counts January and February in the previous year
            if (s1_month_reg[i] < 4'd3)
            begin
                s2_k_next[i] = cent_zero[i] ? 7'd99 : rem100[i] - 7'd1;
                s2_j_next[i] = s2_pq_next[i];
            end
            else
            begin
                s2_k_next[i] = rem100[i];
                s2_j_next[i] = s1_q100_reg[i];
            end
            s2_mt_next[i] = 7'(zeller_month_term(s1_month_reg[i])) + 7'(s1_day_reg[i]);
        end
        s2_ok_next = date_ok[0] && date_ok[1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg)
        begin
            s2_ok_reg <= s2_ok_next;
            for (int i = 0; i < 2; i++)
            begin
                s2_p_reg[i]   <= s2_p_next[i];
                s2_pq_reg[i]  <= s2_pq_next[i];
                s2_dom_reg[i] <= s2_dom_next[i];
                s2_k_reg[i]   <= s2_k_next[i];
                s2_j_reg[i]   <= s2_j_next[i];
                s2_mt_reg[i]  <= s2_mt_next[i];
            end
        end
    end

    // Stage 3 logic: day number and Zeller sum
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            s3_n_next[i] = DAYNUM_W'(s2_p_reg[i]) * 23'd365
                           + DAYNUM_W'(s2_p_reg[i] >> 2)
                           - DAYNUM_W'(s2_pq_reg[i])
                           + DAYNUM_W'(s2_pq_reg[i] >> 2)
                           + DAYNUM_W'(s2_dom_reg[i]);
            s3_zs_next[i] = ZSUM_W'(s2_mt_reg[i])
                            + ZSUM_W'(s2_k_reg[i])
                            + ZSUM_W'(s2_k_reg[i] >> 2)
                            + ZSUM_W'(s2_j_reg[i] >> 2)
                            + ZSUM_W'(s2_j_reg[i]) * 11'd5;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            s3_ok_reg <= s2_ok_reg;
            for (int i = 0; i < 2; i++)
            begin
                s3_n_reg[i]  <= s3_n_next[i];
                s3_zs_reg[i] <= s3_zs_next[i];
            end
        end
    end

    // Stage 4 logic: clamp difference at zero and at the field maximum (zero for invalid dates), Zeller sum / 7
    always_comb
    begin
        n_diff = (s3_n_reg[1] > s3_n_reg[0]) ? s3_n_reg[1] - s3_n_reg[0] : '0;
        if (!s3_ok_reg)
            s4_days_next = '0;
        else if (n_diff > DAYNUM_W'(DAYS_MAX))
            s4_days_next = DAYS_MAX;
        else
            s4_days_next = n_diff[DIFF_W-1:0];
        for (int i = 0; i < 2; i++)
        begin
            div7_prod[i]  = DAYNUM_W'(s3_zs_reg[i]) * DAYNUM_W'(DIV7_MUL);
            s4_q7_next[i] = div7_prod[i][DIV7_SH +: Q7_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && s3_valid_reg)
        begin
            s4_ok_reg   <= s3_ok_reg;
            s4_days_reg <= s4_days_next;
            for (int i = 0; i < 2; i++)
            begin
                s4_zs_reg[i] <= s3_zs_reg[i];
                s4_q7_reg[i] <= s4_q7_next[i];
            end
        end
    end

    // Stage 5 logic: weekday as remainder by 7, zeroed for invalid dates
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rem7[i]       = s4_zs_reg[i] - ZSUM_W'(s4_q7_reg[i]) * 11'd7;
            s5_wd_next[i] = s4_ok_reg ? rem7[i][WDAY_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && s4_valid_reg)
        begin
            s5_ok_reg   <= s4_ok_reg;
            s5_days_reg <= s4_days_reg;
            s5_wd_reg[0] <= s5_wd_next[0];
            s5_wd_reg[1] <= s5_wd_next[1];
        end
    end

    // Output pack
    assign m_axis_tvalid = s5_valid_reg;
    assign m_axis_tuser  = s5_ok_reg;
    assign m_axis_tdata  = {4'b0000, s5_wd_reg[1], s5_wd_reg[0], s5_days_reg};

    // Invalid pairs carry an all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid date pair with nonzero payload");

    // Weekdays stay in Saturday..Friday
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (s5_wd_reg[0] <= 3'd6) && (s5_wd_reg[1] <= 3'd6))
        else $error("weekday out of range");

    // Input stalls only when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                            && s4_valid_reg && s5_valid_reg && !m_axis_tready))
        else $error("input stalled with a free stage");

    // A stalled item in stage 4 is still there next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && !rdy5) |=> s4_valid_reg)
        else $error("stage 4 item dropped during stall");

endmodule
